// ===== src/qsd_pkg.sv =====
// ----------------------------------------------------------------------------
// qsd_pkg
// Shared constants and types for the quadrature speed and distance counter.
// ----------------------------------------------------------------------------
`default_nettype none

package qsd_pkg;

  // Field and register widths
  localparam int unsigned CNT_W         = 32;
  localparam int unsigned OP_W          = 2;
  localparam int unsigned SPEED_SCALE_W = 40;
  localparam int unsigned DIST_SCALE_W  = 25;
  localparam int unsigned CFG_IDX_W     = 4;
  localparam int unsigned FRAC_W        = 16;

  // Speed is updated only for differences strictly inside +/- this limit
  localparam int unsigned DIFF_LIMIT = 100000;

  // Opcodes
  localparam logic [OP_W-1:0] OP_EDGE   = 2'd0;
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_SCALE  = 4'd1;

  // Register reset values (Q24.16 speed scale, Q9.16 distance scale)
  localparam logic [SPEED_SCALE_W-1:0] SPEED_SCALE_RST = 40'd6553600;
  localparam logic [DIST_SCALE_W-1:0]  DIST_SCALE_RST  = 25'd65536;

  // Operand of the fixed-point scaler: magnitude and sign of a count value
  typedef struct packed {
    logic [CNT_W-1:0] mag;
    logic             neg;
  } qsd_mul_t;

  // Contents of the first pipeline stage
  typedef struct packed {
    qsd_mul_t         mul;
    logic             use_speed;  // scale by speed_scale, else distance_scale
    logic             upd_speed;  // in-range speed sample
    logic             is_read;    // distance read
    logic [CNT_W-1:0] count;
  } qsd_stage_t;

endpackage

`default_nettype wire

// ===== src/qsd_scale.sv =====
// ----------------------------------------------------------------------------
// qsd_scale
// Signed value times unsigned Q24.16 scale, truncated toward zero and
// saturated to 32-bit two's complement.
// ----------------------------------------------------------------------------
`default_nettype none

module qsd_scale (
  input  qsd_pkg::qsd_mul_t                   op_i,
  input  logic [qsd_pkg::SPEED_SCALE_W-1:0]   scale_i,
  output logic [qsd_pkg::CNT_W-1:0]           result_o
);
  import qsd_pkg::*;

  localparam int unsigned HI_W   = SPEED_SCALE_W - FRAC_W;
  localparam int unsigned PHI_W  = CNT_W + HI_W;
  localparam int unsigned PLO_W  = CNT_W + FRAC_W;
  localparam int unsigned SUM_W  = PHI_W + 1;

  localparam logic [SUM_W-1:0] POS_MAX = SUM_W'({1'b0, {(CNT_W-1){1'b1}}});
  localparam logic [SUM_W-1:0] NEG_MAX = SUM_W'({1'b1, {(CNT_W-1){1'b0}}});

  logic [HI_W-1:0]   scale_hi;
  logic [FRAC_W-1:0] scale_lo;
  logic [PHI_W-1:0]  prod_hi;
  logic [PLO_W-1:0]  prod_lo;
  logic [SUM_W-1:0]  q;
  logic [CNT_W-1:0]  mag_sat;

  assign scale_hi = scale_i[SPEED_SCALE_W-1:FRAC_W];
  assign scale_lo = scale_i[FRAC_W-1:0];

  // Split the wide scale into integer and fraction partial products
  assign prod_hi = PHI_W'(op_i.mag) * PHI_W'(scale_hi);
  assign prod_lo = PLO_W'(op_i.mag) * PLO_W'(scale_lo);
  assign q       = SUM_W'(prod_hi) + SUM_W'(prod_lo[PLO_W-1:FRAC_W]);

  always_comb begin
    if (op_i.neg) begin
      mag_sat  = (q > NEG_MAX) ? NEG_MAX[CNT_W-1:0] : q[CNT_W-1:0];
      result_o = ~mag_sat + CNT_W'(1);
    end else begin
      mag_sat  = (q > POS_MAX) ? POS_MAX[CNT_W-1:0] : q[CNT_W-1:0];
      result_o = mag_sat;
    end
  end

endmodule

`default_nettype wire

// ===== src/quadrature_speed_distance.sv =====
// ----------------------------------------------------------------------------
// quadrature_speed_distance
// Quadrature tick counter with sampled speed and read-and-clear distance.
// ----------------------------------------------------------------------------
// Pipeline: state update stage, then scale multiply and saturate into the
// output register. Throughput: one item per cycle unless out_ready stalls
// the output; the counter state loop closes within the state update stage.
// Reset: synchronous, active low; counts, held speed and pipeline valids
// clear, scale registers return to 100.0 (Q24.16) and 1.0 (Q9.16).
`default_nettype none

module quadrature_speed_distance (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [qsd_pkg::OP_W-1:0]          in_opcode,
  input  logic                              in_level_a,
  input  logic                              in_level_b,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [qsd_pkg::CNT_W-1:0]  out_speed,
  output logic signed [qsd_pkg::CNT_W-1:0]  out_distance,
  output logic signed [qsd_pkg::CNT_W-1:0]  out_count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [qsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qsd_pkg::SPEED_SCALE_W-1:0] cfg_data
);
  import qsd_pkg::*;

  function automatic logic [CNT_W-1:0] mag32(input logic [CNT_W-1:0] v);
    return v[CNT_W-1] ? (~v + CNT_W'(1)) : v;
  endfunction

  // Configuration
  logic [SPEED_SCALE_W-1:0] speed_scale_r;
  logic [DIST_SCALE_W-1:0]  dist_scale_r;

  // Counter state
  logic [CNT_W-1:0] tick_r, tick_nxt;
  logic [CNT_W-1:0] last_r, last_nxt;
  logic [CNT_W-1:0] tsr_r, tsr_nxt;
  logic [CNT_W-1:0] held_r, held_nxt;
  logic [CNT_W-1:0] diff;
  logic [CNT_W-1:0] diff_mag;

  // Pipeline
  qsd_stage_t       s1_r, s1_nxt;
  logic             s1_valid_r;
  logic             out_valid_r;
  logic [CNT_W-1:0] out_speed_r, out_speed_nxt;
  logic [CNT_W-1:0] out_dist_r, out_dist_nxt;
  logic [CNT_W-1:0] out_count_r;
  logic             en1, en2, in_acc, load2;

  logic [SPEED_SCALE_W-1:0] scale_sel;
  logic [CNT_W-1:0]         scaled;

  assign cfg_ready = 1'b1;

  assign en2      = !out_valid_r || out_ready;
  assign en1      = !s1_valid_r || en2;
  assign in_ready = en1;
  assign in_acc   = in_valid && en1;
  assign load2    = s1_valid_r && en2;

  // Stage 1: counter state update and scaler operand
  always_comb begin
    tick_nxt = tick_r;
    last_nxt = last_r;
    tsr_nxt  = tsr_r;
    diff     = tick_r - last_r;
    diff_mag = mag32(diff);
    s1_nxt   = '0;
    case (in_opcode)
      OP_EDGE: begin
        tick_nxt = (in_level_a == in_level_b) ? tick_r + CNT_W'(1) : tick_r - CNT_W'(1);
      end
      OP_SAMPLE: begin
        last_nxt             = tick_r;
        tsr_nxt              = tsr_r + diff;
        s1_nxt.mul.mag       = diff_mag;
        s1_nxt.mul.neg       = diff[CNT_W-1];
        s1_nxt.use_speed     = 1'b1;
        s1_nxt.upd_speed     = diff_mag < CNT_W'(DIFF_LIMIT);
      end
      OP_READ: begin
        tsr_nxt        = '0;
        s1_nxt.mul.mag = mag32(tsr_r);
        s1_nxt.mul.neg = tsr_r[CNT_W-1];
        s1_nxt.is_read = 1'b1;
      end
      default: begin
      end
    endcase
    s1_nxt.count = tick_nxt;
  end

  // Stage 2: scale, saturate, hold speed
  assign scale_sel = s1_r.use_speed ? speed_scale_r : SPEED_SCALE_W'(dist_scale_r);

  qsd_scale u_scale (
    .op_i     (s1_r.mul),
    .scale_i  (scale_sel),
    .result_o (scaled)
  );

  always_comb begin
    held_nxt      = (load2 && s1_r.upd_speed) ? scaled : held_r;
    out_speed_nxt = s1_r.upd_speed ? scaled : held_r;
    out_dist_nxt  = s1_r.is_read ? scaled : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_scale_r <= SPEED_SCALE_RST;
      dist_scale_r  <= DIST_SCALE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SPEED_SCALE: speed_scale_r <= cfg_data;
        CFG_DIST_SCALE:  dist_scale_r  <= cfg_data[DIST_SCALE_W-1:0];
        default: begin
          // drop writes to unknown registers
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r      <= '0;
      last_r      <= '0;
      tsr_r       <= '0;
      held_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        tick_r <= tick_nxt;
        last_r <= last_nxt;
        tsr_r  <= tsr_nxt;
      end
      held_r <= held_nxt;
      if (en1) begin
        s1_valid_r <= in_valid;
      end
      if (en2) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
    if (load2) begin
      out_speed_r <= out_speed_nxt;
      out_dist_r  <= out_dist_nxt;
      out_count_r <= s1_r.count;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_speed    = out_speed_r;
  assign out_distance = out_dist_r;
  assign out_count    = out_count_r;

endmodule

`default_nettype wire

// ===== src/qsd_checker.sv =====
// ----------------------------------------------------------------------------
// qsd_checker
// Port-level checks for the quadrature speed and distance counter.
// ----------------------------------------------------------------------------
`default_nettype none

module qsd_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [qsd_pkg::CNT_W-1:0]  out_speed,
  input logic signed [qsd_pkg::CNT_W-1:0]  out_distance,
  input logic signed [qsd_pkg::CNT_W-1:0]  out_count
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // An empty output register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk)
    disable iff (!rst_n) !out_valid |-> in_ready)
    else $error("in_ready low while output is empty");

  // An accepted transaction reaches the output register through stage 1 if out_ready does not stall it
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("result missing two cycles after acceptance");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_speed)
      && $stable(out_distance) && $stable(out_count))
    else $error("stalled result changed");

endmodule

bind quadrature_speed_distance qsd_checker u_qsd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_speed    (out_speed),
  .out_distance (out_distance),
  .out_count    (out_count)
);

`default_nettype wire

// ===== tb/tb_quadrature_speed_distance.sv =====
// ----------------------------------------------------------------------------
// tb_quadrature_speed_distance
// Self-checking bench for the quadrature tick counter with speed and distance.
// A queue-fed driver offers opcodes with random gaps. A monitor with random
// back-pressure compares every result against an in-bench predictor of count,
// held speed and read-and-clear distance. Scale registers are rewritten
// between drained phases, including both extremes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_quadrature_speed_distance;
  import qsd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE   = 4'd15;
  localparam int                   HOLD_CYC   = 60;
  localparam int                   LAT_PAD    = 6;
  localparam int                   RAND_ITEMS = 85;
  localparam logic [SPEED_SCALE_W-1:0] SPD_MAX = '1;
  localparam logic [DIST_SCALE_W-1:0]  DST_MAX = 25'd23592960;

  typedef struct {
    logic [OP_W-1:0] op;
    logic            a;
    logic            b;
  } enc_item_t;

  typedef struct {
    logic signed [CNT_W-1:0] speed;
    logic signed [CNT_W-1:0] distance;
    logic signed [CNT_W-1:0] count;
  } motion_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [OP_W-1:0]          in_opcode = OP_EDGE;
  logic                     in_level_a = 1'b0;
  logic                     in_level_b = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [CNT_W-1:0]  out_speed;
  logic signed [CNT_W-1:0]  out_distance;
  logic signed [CNT_W-1:0]  out_count;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = CFG_SPEED_SCALE;
  logic [SPEED_SCALE_W-1:0] cfg_data = '0;

  quadrature_speed_distance dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_opcode   (in_opcode),
    .in_level_a  (in_level_a),
    .in_level_b  (in_level_b),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_speed   (out_speed),
    .out_distance(out_distance),
    .out_count   (out_count),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // Predictor state
  logic [CNT_W-1:0]         ticks = '0;
  logic [CNT_W-1:0]         ticks_at_sample = '0;
  logic [CNT_W-1:0]         travel_ticks = '0;
  logic [CNT_W-1:0]         speed_hold = '0;
  logic [SPEED_SCALE_W-1:0] spd_k = SPEED_SCALE_RST;
  logic [DIST_SCALE_W-1:0]  dst_k = DIST_SCALE_RST;

  enc_item_t pend_q[$];
  motion_t   motion_q[$];

  logic bursts_on = 1'b1;
  logic hold_go = 1'b0;
  logic rx_hold = 1'b0;
  int   tx_gap = 0;
  int   rx_gap = 0;
  int   n_in = 0;
  int   n_out = 0;
  int   n_cfg = 0;
  int   n_err = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", motion_q.size());
    $display("tb_quadrature_speed_distance NOT OK");
    $finish;
  end

  // Signed value times unsigned Q24.16 factor, truncated toward zero, saturated
  function automatic logic [CNT_W-1:0] fx_mul_sat(input logic [CNT_W-1:0] v,
                                                  input logic [SPEED_SCALE_W-1:0] k);
    logic [CNT_W-1:0] mag;
    logic [71:0]      prod;
    logic [55:0]      q;
    mag  = v[CNT_W-1] ? (32'd0 - v) : v;
    prod = 72'(mag) * 72'(k);
    q    = prod[71:16];
    if (!v[CNT_W-1]) begin
      if (q > 56'h7FFF_FFFF) q = 56'h7FFF_FFFF;
      return q[31:0];
    end
    if (q > 56'h8000_0000) q = 56'h8000_0000;
    return 32'd0 - q[31:0];
  endfunction

  task automatic predict_motion(input logic [OP_W-1:0] op, input logic a, input logic b);
    logic [CNT_W-1:0] diff;
    logic [CNT_W-1:0] dmag;
    motion_t          m;
    m.distance = '0;
    case (op)
      OP_EDGE: begin
        ticks = (a == b) ? ticks + 32'd1 : ticks - 32'd1;
      end
      OP_SAMPLE: begin
        diff = ticks - ticks_at_sample;
        ticks_at_sample = ticks;
        travel_ticks = travel_ticks + diff;
        dmag = diff[CNT_W-1] ? (32'd0 - diff) : diff;
        if (dmag < DIFF_LIMIT) speed_hold = fx_mul_sat(diff, spd_k);
      end
      OP_READ: begin
        m.distance = fx_mul_sat(travel_ticks, SPEED_SCALE_W'(dst_k));
        travel_ticks = '0;
      end
      default: begin
      end
    endcase
    m.speed = speed_hold;
    m.count = ticks;
    motion_q.push_back(m);
  endtask

  task automatic check_field(input string name, input logic signed [CNT_W-1:0] want,
                             input logic signed [CNT_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_err++;
    end
  endtask

  // Driver: present queued items, hold until accepted, random gaps between
  always @(posedge clk) begin : drv
    enc_item_t nxt;
    logic      busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        predict_motion(in_opcode, in_level_a, in_level_b);
        n_in++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          if (bursts_on && $urandom_range(0, 7) == 0) begin
            tx_gap <= $urandom_range(0, 4);
            in_valid <= 1'b0;
          end else begin
            nxt = pend_q.pop_front();
            in_opcode <= nxt.op;
            in_level_a <= nxt.a;
            in_level_b <= nxt.b;
            in_valid <= 1'b1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each transaction with the oldest expectation
  always @(posedge clk) begin : mon
    motion_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_out++;
        if (motion_q.size() == 0) begin
          $error("result with nothing expected: speed %0d distance %0d count %0d",
                 out_speed, out_distance, out_count);
          n_err++;
        end else begin
          want = motion_q.pop_front();
          check_field("speed", want.speed, out_speed);
          check_field("distance", want.distance, out_distance);
          check_field("count", want.count, out_count);
        end
      end
      if (rx_hold) begin
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_ready <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 7) == 0) begin
        rx_gap <= $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off so the pipeline fills and stalls its input
  initial begin : hold_off
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYC) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic push_item(input logic [OP_W-1:0] op, input logic a, input logic b);
    enc_item_t it;
    it.op = op;
    it.a  = a;
    it.b  = b;
    pend_q.push_back(it);
  endtask

  task automatic push_edges(input int n, input logic up);
    logic a;
    for (int i = 0; i < n; i++) begin
      a = 1'($urandom_range(0, 1));
      push_item(OP_EDGE, a, up ? a : ~a);
    end
  endtask

  // Mostly edge runs closed by a sample, some reads, the rest noise
  task automatic push_random(input int n);
    int   left;
    int   run;
    logic up;
    logic a;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 99) < 80) begin
        run = $urandom_range(1, 30);
        up  = 1'($urandom_range(0, 1));
        for (int i = 0; i < run; i++) begin
          if ($urandom_range(0, 7) == 0) up = ~up;
          a = 1'($urandom_range(0, 1));
          push_item(OP_EDGE, a, up ? a : ~a);
        end
        push_item(OP_SAMPLE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        left -= run + 1;
        if ($urandom_range(0, 3) == 0) begin
          push_item(OP_READ, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          left--;
        end
      end else begin
        push_item(OP_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
        left--;
      end
    end
  endtask

  // Sample at the falling edge so the driver and monitor updates have settled
  task automatic drain;
    while (pend_q.size() != 0 || in_valid || motion_q.size() != 0) @(negedge clk);
    repeat (LAT_PAD) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [SPEED_SCALE_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SPEED_SCALE: spd_k = data;
      CFG_DIST_SCALE:  dst_k = data[DIST_SCALE_W-1:0];
      default: begin
      end
    endcase
    n_cfg++;
    cfg_valid <= 1'b0;
  endtask

  task automatic write_random_scales;
    logic [63:0] r;
    r = {$urandom, $urandom};
    write_reg(CFG_SPEED_SCALE, r[SPEED_SCALE_W-1:0]);
    write_reg(CFG_DIST_SCALE, SPEED_SCALE_W'($urandom_range(0, DST_MAX)));
  endtask

  initial begin : stim
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset scales: unused opcode, empty read, zero sample, all four level pairs
    push_item(OP_UNUSED, 1'b0, 1'b0);
    push_item(OP_READ, 1'b0, 1'b0);
    push_item(OP_SAMPLE, 1'b0, 1'b0);
    push_item(OP_EDGE, 1'b0, 1'b0);
    push_item(OP_EDGE, 1'b1, 1'b1);
    push_item(OP_EDGE, 1'b0, 1'b1);
    push_item(OP_EDGE, 1'b1, 1'b0);
    push_edges(3, 1'b1);
    push_item(OP_SAMPLE, 1'b0, 1'b0);
    // levels on non-edge opcodes are ignored
    push_item(OP_UNUSED, 1'b1, 1'b0);
    push_item(OP_SAMPLE, 1'b0, 1'b1);
    push_edges(2, 1'b0);
    push_item(OP_SAMPLE, 1'b1, 1'b1);
    push_item(OP_READ, 1'b1, 1'b0);
    push_item(OP_READ, 1'b0, 1'b0);
    drain();

    // Fractional scales: negative products truncate toward zero
    write_reg(CFG_SPEED_SCALE, 40'h1_8000);
    write_reg(CFG_DIST_SCALE, 40'h8000);
    push_edges(1, 1'b0);
    push_item(OP_SAMPLE, 1'b0, 1'b0);
    push_edges(3, 1'b1);
    push_item(OP_SAMPLE, 1'b0, 1'b0);
    push_item(OP_READ, 1'b0, 1'b0);
    push_edges(1, 1'b0);
    push_item(OP_SAMPLE, 1'b0, 1'b0);
    push_item(OP_READ, 1'b0, 1'b0);
    drain();

    // Maximum scales; an unknown register index changes nothing
    write_reg(CFG_SPEED_SCALE, SPD_MAX);
    write_reg(CFG_DIST_SCALE, SPEED_SCALE_W'(DST_MAX));
    write_reg(CFG_NONE, SPEED_SCALE_W'({$urandom, $urandom}));
    push_item(OP_SAMPLE, 1'b0, 1'b0);
    push_edges(1, 1'b1);
    push_item(OP_SAMPLE, 1'b0, 1'b0);
    push_item(OP_READ, 1'b0, 1'b0);
    // Speed saturates at both ends once the difference passes 128 ticks
    push_edges(150, 1'b1);
    push_item(OP_SAMPLE, 1'b0, 1'b0);
    push_edges(160, 1'b0);
    push_item(OP_SAMPLE, 1'b0, 1'b0);
    push_item(OP_READ, 1'b0, 1'b0);
    drain();

    // Random phases; the first runs under a long receiver hold-off
    write_random_scales();
    hold_go = 1'b1;
    push_random(RAND_ITEMS);
    drain();

    write_reg(CFG_SPEED_SCALE, '0);
    write_reg(CFG_DIST_SCALE, '0);
    push_random(RAND_ITEMS);
    drain();

    write_reg(CFG_SPEED_SCALE, SPEED_SCALE_W'($urandom_range(0, 32'h00FF_FFFF)));
    write_reg(CFG_DIST_SCALE, SPEED_SCALE_W'($urandom_range(0, DST_MAX)));
    push_random(RAND_ITEMS);
    drain();

    write_reg(CFG_SPEED_SCALE, SPD_MAX);
    write_reg(CFG_DIST_SCALE, SPEED_SCALE_W'(DST_MAX));
    push_random(RAND_ITEMS);
    drain();

    // Closing stretch at full rate on both sides
    write_random_scales();
    bursts_on = 1'b0;
    push_random(RAND_ITEMS);
    drain();

    $display("covered %0d input transactions, %0d checked results, %0d register writes",
             n_in, n_out, n_cfg);
    $display("saturation at both ends, truncation, unused opcode, pressure stall");
    if (n_err == 0) begin
      $display("tb_quadrature_speed_distance OK");
    end else begin
      $display("tb_quadrature_speed_distance NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
